[rtl/irfr_pkg.sv]
// shared types, constants and the crc-8 step for the frame receiver
// used by irfr_front, irfr_queue, irfr_back and the top level
package irfr_pkg;

    // payload buffer per frame and frame layout
    localparam int MAX_PAYLOAD  = 32;
    localparam int HEADER_BYTES = 8;
    localparam int IDX_W        = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PLEN_W       = $clog2(MAX_PAYLOAD + 1);

    // two payload banks, one descriptor slot per bank
    localparam int NBANK     = 2;
    localparam int BANK_W    = 1;
    localparam int MEM_DEPTH = NBANK << IDX_W;
    localparam int MADDR_W   = BANK_W + IDX_W;

    // configuration register indexes and reset values
    localparam logic [1:0] REG_FIRST_PREAMBLE  = 2'd0;
    localparam logic [1:0] REG_SECOND_PREAMBLE = 2'd1;
    localparam logic [1:0] REG_RX_ENABLE       = 2'd2;
    localparam logic [7:0] FIRST_PREAMBLE_RST  = 8'd90;
    localparam logic [7:0] SECOND_PREAMBLE_RST = 8'd84;

    localparam logic [7:0] CRC_POLY = 8'h31;

    // one good frame handed from front to back
    typedef struct packed {
        logic [15:0]        seq;
        logic [47:0]        mac;
        logic [PLEN_W-1:0]  plen;
        logic [BANK_W-1:0]  bank;
    } desc_t;

    // payload buffer write from the front
    typedef struct packed {
        logic               en;
        logic [MADDR_W-1:0] addr;
        logic [7:0]         data;
    } buf_wr_t;

    // crc-8, msb first, one byte
    function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

[rtl/irfr_queue.sv]
// two-entry descriptor queue between the front parser and the back emitter
// depends on irfr_pkg for desc_t
module irfr_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  irfr_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            head_valid,
    output irfr_pkg::desc_t head_desc,
    output logic            full
);
    import irfr_pkg::*;

    desc_t      entry_reg [NBANK];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);
    assign head_desc  = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3) else $error("queue count out of range");

endmodule

[rtl/irfr_front.sv]
// front parser: config registers, preamble hunt, header capture, crc check
// depends on irfr_pkg; writes payload into the back's buffer, pushes descriptors
module irfr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    input  logic              q_full,
    output logic              q_push,
    output irfr_pkg::desc_t   q_desc,
    output irfr_pkg::buf_wr_t buf_wr
);
    import irfr_pkg::*;

    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_SECOND = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_GATHER = 3'd3;
    localparam logic [2:0] PH_CHECK  = 3'd4;

    logic [7:0]  first_pre_reg, second_pre_reg;
    logic        rx_en_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] seq_reg, seq_next;
    logic [47:0] mac_reg, mac_next;
    logic        bank_reg, bank_next;

    logic        accept;
    logic [7:0]  b;
    logic [2:0]  restart_phase;
    logic [7:0]  pidx;
    logic [7:0]  cnt_inc;
    logic [7:0]  plen_full;
    logic [7:0]  crc_step;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_pre_reg  <= FIRST_PREAMBLE_RST;
            second_pre_reg <= SECOND_PREAMBLE_RST;
            rx_en_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FIRST_PREAMBLE:  first_pre_reg  <= cfg_wr_data;
                REG_SECOND_PREAMBLE: second_pre_reg <= cfg_wr_data;
                REG_RX_ENABLE:       rx_en_reg      <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // stall only while both payload banks are held by good frames
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready && rx_en_reg;
    assign b       = s_rx_byte;

    assign restart_phase = (b == first_pre_reg) ? PH_SECOND : PH_FIRST;
    assign pidx          = cnt_reg - 8'(HEADER_BYTES);
    assign cnt_inc       = cnt_reg + 8'd1;
    assign plen_full     = len_reg - 8'(HEADER_BYTES);
    assign crc_step      = crc8_add((phase_reg == PH_LENGTH) ? 8'd0 : crc_reg, b);

    // hunt and gather sequencing
    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        seq_next   = seq_reg;
        mac_next   = mac_reg;
        bank_next  = bank_reg;
        q_push     = 1'b0;
        buf_wr.en   = 1'b0;
        buf_wr.addr = {bank_reg, pidx[IDX_W-1:0]};
        buf_wr.data = b;
        if (accept) begin
            unique case (phase_reg)
                PH_FIRST: phase_next = restart_phase;
                PH_SECOND: begin
                    phase_next = (b == second_pre_reg) ? PH_LENGTH : restart_phase;
                end
                PH_LENGTH: begin
                    if (b < 8'(HEADER_BYTES)) begin
                        phase_next = restart_phase;
                    end else begin
                        len_next   = b;
                        cnt_next   = 8'd0;
                        crc_next   = crc_step;
                        phase_next = PH_GATHER;
                    end
                end
                PH_GATHER: begin
                    crc_next = crc_step;
                    cnt_next = cnt_inc;
                    if (cnt_reg == 8'd0) begin
                        seq_next[7:0] = b;
                    end else if (cnt_reg == 8'd1) begin
                        seq_next[15:8] = b;
                    end else if (cnt_reg < 8'(HEADER_BYTES)) begin
                        mac_next[8*(cnt_reg[2:0]-3'd2) +: 8] = b;
                    end else if (pidx < 8'(MAX_PAYLOAD)) begin
                        buf_wr.en = 1'b1;
                    end
                    if (cnt_inc >= len_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase_next = PH_FIRST;
                    if (b == crc_reg) begin
                        q_push    = 1'b1;
                        bank_next = ~bank_reg;
                    end
                end
                default: phase_next = PH_FIRST;
            endcase
        end
    end

    // descriptor of the frame just checked
    always_comb begin
        q_desc.seq  = seq_reg;
        q_desc.mac  = mac_reg;
        q_desc.bank = bank_reg;
        q_desc.plen = (plen_full > 8'(MAX_PAYLOAD)) ? PLEN_W'(MAX_PAYLOAD)
                                                   : plen_full[PLEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            crc_reg   <= 8'd0;
            bank_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            bank_reg  <= bank_next;
        end
    end

    // header holders
    always_ff @(posedge aclk) begin
        seq_reg <= seq_next;
        mac_reg <= mac_next;
    end

endmodule

[rtl/irfr_back.sv]
// back emitter: payload buffer and one result per cycle from the queue head while m_ready allows
// depends on irfr_pkg for desc_t and buf_wr_t
module irfr_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  irfr_pkg::buf_wr_t buf_wr,
    input  logic              head_valid,
    input  irfr_pkg::desc_t   head_desc,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_sequence_number,
    output logic [47:0]       m_src_addr,
    output logic [5:0]        m_payload_length,
    output logic [7:0]        m_payload_byte,
    output logic [4:0]        m_byte_index,
    output logic              m_last_of_frame
);
    import irfr_pkg::*;

    logic [7:0]        mem [MEM_DEPTH];
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg;
    logic [15:0]       out_seq_reg;
    logic [47:0]       out_mac_reg;
    logic [PLEN_W-1:0] out_plen_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_last_reg;
    logic [7:0]        rd_data_reg;

    logic              advance;
    logic              last;

    // payload buffer write port
    always_ff @(posedge aclk) begin
        if (buf_wr.en) begin
            mem[buf_wr.addr] <= buf_wr.data;
        end
    end

    assign advance = head_valid && (!out_valid_reg || m_ready);
    assign last    = (head_desc.plen == '0) ||
                     (PLEN_W'(idx_reg) == head_desc.plen - PLEN_W'(1));
    assign pop     = advance && last;
    assign idx_next = last ? '0 : idx_reg + IDX_W'(1);

    // result index and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            idx_reg       <= idx_next;
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register with buffer read
    always_ff @(posedge aclk) begin
        if (advance) begin
            rd_data_reg  <= mem[{head_desc.bank, idx_reg}];
            out_seq_reg  <= head_desc.seq;
            out_mac_reg  <= head_desc.mac;
            out_plen_reg <= head_desc.plen;
            out_idx_reg  <= idx_reg;
            out_last_reg <= last;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_sequence_number = out_seq_reg;
    assign m_src_addr        = out_mac_reg;
    assign m_payload_length  = 6'(out_plen_reg);
    assign m_payload_byte    = (out_plen_reg == '0) ? 8'd0 : rd_data_reg;
    assign m_byte_index      = 5'(out_idx_reg);
    assign m_last_of_frame   = out_last_reg;

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_plen_reg == '0) |-> out_last_reg)
        else $error("empty frame result not marked last");
    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_plen_reg != '0) |-> (PLEN_W'(out_idx_reg) < out_plen_reg))
        else $error("byte index past payload length");
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_seq_reg) &&
                                         $stable(out_idx_reg) && $stable(out_last_reg)))
        else $error("result changed while stalled");

endmodule

[rtl/ir_frame_receiver_crc8_top.sv]
// top level of the preamble / length / crc-8 frame receiver
// depends on irfr_pkg, irfr_front, irfr_queue and irfr_back
//
// usage:
//   s_ channel: one received byte per item (s_rx_byte), valid/ready handshake.
//   m_ channel: one result per stored payload byte of a good frame, or one
//   result for a frame without payload; m_last_of_frame marks the final one.
//   cfg port: cfg_wr_en with cfg_index 0/1/2 writes first preamble, second
//   preamble and the receive enable; other indexes are ignored.
// timing:
//   a byte is taken every cycle while s_ready is high; the first result of a
//   good frame is registered from the queue head once its crc byte has
//   pushed the descriptor, then one result per cycle while m_ready allows.
//   two good frames can be held (one payload bank each); with both held,
//   s_ready drops until the back part finishes the older frame.
// reset:
//   preambles return to Z and T, receiving is disabled, the hunt restarts
//   and any pending results are discarded.
// stall:
//   while m_ready is low the result holds; parsing continues into the free
//   bank until both banks are taken.
module ir_frame_receiver_crc8_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_sequence_number,
    output logic [47:0] m_src_addr,
    output logic [5:0]  m_payload_length,
    output logic [7:0]  m_payload_byte,
    output logic [4:0]  m_byte_index,
    output logic        m_last_of_frame
);
    import irfr_pkg::*;

    logic    q_full;
    logic    q_push;
    desc_t   q_desc;
    buf_wr_t buf_wr;
    logic    head_valid;
    desc_t   head_desc;
    logic    pop;

    // parser
    irfr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_desc      (q_desc),
        .buf_wr      (buf_wr)
    );

    // frame descriptor queue
    irfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_desc),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .full       (q_full)
    );

    // result emitter
    irfr_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .buf_wr            (buf_wr),
        .head_valid        (head_valid),
        .head_desc         (head_desc),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sequence_number (m_sequence_number),
        .m_src_addr        (m_src_addr),
        .m_payload_length  (m_payload_length),
        .m_payload_byte    (m_payload_byte),
        .m_byte_index      (m_byte_index),
        .m_last_of_frame   (m_last_of_frame)
    );

endmodule
